>>> rtl/core/lps_pkg.sv
`timescale 1ns / 1ps

package lps_pkg;

   // Coordinate width inside the stepper; the port fields stay 10 bits.
   localparam int COORD_BITS = 10;
   localparam int FIELD_BITS = 10;
   localparam int COLOR_BITS = 16;
   localparam int ERR_BITS   = COORD_BITS + 1;

   localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

   // Item kinds carried on req_tuser
   localparam logic ACT_START   = 1'b0;
   localparam logic ACT_ADVANCE = 1'b1;

   // Step direction codes
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_INC  = 2'd1;
   localparam logic [1:0] DIR_DEC  = 2'd3;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [ERR_BITS-1:0]   err_type;

   typedef struct packed {
      coord_type  mag;
      logic [1:0] dir;
   } delta_type;

   // One emitted pixel as it travels from the stepper to the output stage
   typedef struct packed {
      logic [FIELD_BITS-1:0] pixel_x;
      logic [FIELD_BITS-1:0] pixel_y;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  last;
   } pix_type;

   // Low COORD_BITS of a port field, zero-extended when the field is narrower.
   function automatic coord_type coord_from_field(input logic [FIELD_BITS-1:0] f);
      logic [COORD_BITS+FIELD_BITS-1:0] wide;
      wide = {{COORD_BITS{1'b0}}, f};
      return wide[COORD_BITS-1:0];
   endfunction

   // Low FIELD_BITS of an internal coordinate.
   function automatic logic [FIELD_BITS-1:0] field_from_coord(input coord_type c);
      logic [COORD_BITS+FIELD_BITS-1:0] wide;
      wide = {{FIELD_BITS{1'b0}}, c};
      return wide[FIELD_BITS-1:0];
   endfunction

   function automatic delta_type calc_delta(input coord_type from, input coord_type to);
      delta_type d;
      if (to > from) begin
         d.dir = DIR_INC;
         d.mag = to - from;
      end else if (to < from) begin
         d.dir = DIR_DEC;
         d.mag = from - to;
      end else begin
         d.dir = DIR_NONE;
         d.mag = '0;
      end
      return d;
   endfunction

   // One step, held at the coordinate range ends.
   function automatic coord_type move_coord(input coord_type pos, input logic [1:0] dir);
      coord_type r;
      r = pos;
      case (dir)
         DIR_INC: if (pos != COORD_MAX) r = pos + COORD_BITS'(1);
         DIR_DEC: if (pos != '0) r = pos - COORD_BITS'(1);
         default: r = pos;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/lps_stepper.sv
`timescale 1ns / 1ps

module lps_stepper import lps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_accept,
   input  logic                  action,
   input  logic [FIELD_BITS-1:0] x_start,
   input  logic [FIELD_BITS-1:0] y_start,
   input  logic [FIELD_BITS-1:0] x_end,
   input  logic [FIELD_BITS-1:0] y_end,
   input  logic [COLOR_BITS-1:0] draw_color,
   output logic                  res_valid,
   output pix_type               res_pix
);

   logic       busy_ff, busy_in;
   coord_type  cur_col_ff, cur_col_in;
   coord_type  cur_row_ff, cur_row_in;
   err_type    col_error_ff, col_error_in;
   err_type    row_error_ff, row_error_in;
   coord_type  abs_dcol_ff, abs_dcol_in;
   coord_type  abs_drow_ff, abs_drow_in;
   coord_type  major_ff, major_in;
   logic [1:0] col_dir_ff, col_dir_in;
   logic [1:0] row_dir_ff, row_dir_in;
   err_type    pixels_left_ff, pixels_left_in;

   coord_type  xs, ys, xe, ye;
   delta_type  dcol, drow;
   coord_type  new_major;
   err_type    major_ext;
   err_type    col_sum, row_sum;
   err_type    left_dec;

   assign xs = coord_from_field(x_start);
   assign ys = coord_from_field(y_start);
   assign xe = coord_from_field(x_end);
   assign ye = coord_from_field(y_end);

   assign dcol      = calc_delta(xs, xe);
   assign drow      = calc_delta(ys, ye);
   assign new_major = (dcol.mag > drow.mag) ? dcol.mag : drow.mag;

   assign major_ext = {1'b0, major_ff};
   assign col_sum   = col_error_ff + {1'b0, abs_dcol_ff};
   assign row_sum   = row_error_ff + {1'b0, abs_drow_ff};
   assign left_dec  = pixels_left_ff - ERR_BITS'(1);

   always_comb begin
      busy_in        = busy_ff;
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      col_error_in   = col_error_ff;
      row_error_in   = row_error_ff;
      abs_dcol_in    = abs_dcol_ff;
      abs_drow_in    = abs_drow_ff;
      major_in       = major_ff;
      col_dir_in     = col_dir_ff;
      row_dir_in     = row_dir_ff;
      pixels_left_in = pixels_left_ff;
      res_valid      = 1'b0;

      res_pix.pixel_x     = field_from_coord(cur_col_ff);
      res_pix.pixel_y     = field_from_coord(cur_row_ff);
      res_pix.pixel_color = draw_color;
      res_pix.last        = (left_dec == '0);

      if (item_accept) begin
         if (action == ACT_START) begin
            // restart from scratch, also while a line is running
            busy_in        = 1'b1;
            cur_col_in     = xs;
            cur_row_in     = ys;
            col_error_in   = '0;
            row_error_in   = '0;
            abs_dcol_in    = dcol.mag;
            abs_drow_in    = drow.mag;
            col_dir_in     = dcol.dir;
            row_dir_in     = drow.dir;
            major_in       = new_major;
            pixels_left_in = {1'b0, new_major} + ERR_BITS'(2);
         end else if (busy_ff) begin
            res_valid      = 1'b1;
            pixels_left_in = left_dec;
            if (left_dec == '0) begin
               busy_in = 1'b0;
            end
            col_error_in = col_sum;
            row_error_in = row_sum;
            if (col_sum > major_ext) begin
               col_error_in = col_sum - major_ext;
               cur_col_in   = move_coord(cur_col_ff, col_dir_ff);
            end
            if (row_sum > major_ext) begin
               row_error_in = row_sum - major_ext;
               cur_row_in   = move_coord(cur_row_ff, row_dir_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         col_error_ff   <= '0;
         row_error_ff   <= '0;
         abs_dcol_ff    <= '0;
         abs_drow_ff    <= '0;
         major_ff       <= '0;
         col_dir_ff     <= DIR_NONE;
         row_dir_ff     <= DIR_NONE;
         pixels_left_ff <= '0;
      end else begin
         busy_ff        <= busy_in;
         cur_col_ff     <= cur_col_in;
         cur_row_ff     <= cur_row_in;
         col_error_ff   <= col_error_in;
         row_error_ff   <= row_error_in;
         abs_dcol_ff    <= abs_dcol_in;
         abs_drow_ff    <= abs_drow_in;
         major_ff       <= major_in;
         col_dir_ff     <= col_dir_in;
         row_dir_ff     <= row_dir_in;
         pixels_left_ff <= pixels_left_in;
      end
   end

`ifndef SYNTHESIS
   a_busy_has_pixels: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pixels_left_ff != '0))
      else $error("busy with no pixels left");

   a_err_bounded: assert property (@(posedge clock) disable iff (reset)
      (col_error_ff <= major_ext) && (row_error_ff <= major_ext))
      else $error("error term above major distance");

   a_major_is_max: assert property (@(posedge clock) disable iff (reset)
      (major_ff >= abs_dcol_ff) && (major_ff >= abs_drow_ff))
      else $error("major distance below a delta");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_pix.last && !(item_accept && action == ACT_START)) |=> !busy_ff)
      else $error("still busy after last pixel");
`endif

endmodule

>>> rtl/core/lps_out_stage.sv
`timescale 1ns / 1ps

module lps_out_stage import lps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  pix_type in_pix,
   output logic    in_ready,
   output logic    out_valid,
   output pix_type out_pix,
   input  logic    out_ready
);

   logic    main_valid_ff, main_valid_in;
   pix_type main_pix_ff, main_pix_in;
   logic    skid_valid_ff, skid_valid_in;
   pix_type skid_pix_ff, skid_pix_in;

   // space is known from the registered skid flag: the skid slot catches the one in flight
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_pix   = main_pix_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_pix_in   = main_pix_ff;
      skid_valid_in = skid_valid_ff;
      skid_pix_in   = skid_pix_ff;
      if (out_ready || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_pix_in   = skid_pix_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_pix_in   = in_pix;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_pix_in   = in_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_pix_ff <= main_pix_in;
      skid_pix_ff <= skid_pix_in;
   end

`ifndef SYNTHESIS
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid slot filled ahead of main slot");

   a_skid_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(main_valid_ff && !out_ready && in_valid))
      else $error("skid slot filled without a stall");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> !skid_valid_ff)
      else $error("skid slot not drained");
`endif

endmodule

>>> rtl/core/line_pixel_stepper_top.sv
`timescale 1ns / 1ps

// A pixel is formed combinationally at its advance transfer and registered in
// the output stage before rsp_tvalid; it waits longer only while rsp stalls.
// Throughput: one item per cycle; req_tready only drops while the two-deep
// output stage is full behind a stalled rsp side.
// Reset: synchronous, active high; clears the line state (idle), the output
// stage and the draw color (to 0).
module line_pixel_stepper_top import lps_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // x_start[9:0], y_start[19:10], x_end[29:20], y_end[39:30]
   input  logic        req_tuser,   // action: 0 start line, 1 advance one pixel

   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // pixel_x[9:0], pixel_y[19:10], pixel_color[35:20], zero pad
   output logic        rsp_tlast,   // last pixel of the line

   // color register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [COLOR_BITS-1:0] draw_color_ff;

   logic    req_xfer;
   logic    step_valid;
   pix_type step_pix;
   logic    stage_ready;
   pix_type out_pix;

   // Write only while idle so every line pixel sees one value; the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         draw_color_ff <= '0;
      end else if (csr_wr_en) begin
         draw_color_ff <= csr_wr_data;
      end
   end

   assign req_tready = stage_ready;
   assign req_xfer   = req_tvalid && req_tready;

   // Line state and the per-pixel step; a start transfer yields no pixel,
   // an advance while idle is dropped.
   lps_stepper u_stepper (
      .clock       (clock),
      .reset       (reset),
      .item_accept (req_xfer),
      .action      (req_tuser),
      .x_start     (req_tdata[9:0]),
      .y_start     (req_tdata[19:10]),
      .x_end       (req_tdata[29:20]),
      .y_end       (req_tdata[39:30]),
      .draw_color  (draw_color_ff),
      .res_valid   (step_valid),
      .res_pix     (step_pix)
   );

   // Result register plus skid slot, which holds one more pixel while rsp stalls.
   lps_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step_valid),
      .in_pix    (step_pix),
      .in_ready  (stage_ready),
      .out_valid (rsp_tvalid),
      .out_pix   (out_pix),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {4'b0, out_pix.pixel_color, out_pix.pixel_y, out_pix.pixel_x};
   assign rsp_tlast = out_pix.last;

endmodule

>>> tb/sv/line_pixel_checker.sv
`timescale 1ns / 1ps

module line_pixel_checker import lps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          fail_count,
   output int          pixels_pending
);

   // pixels owed by the block, oldest first
   pix_type               owed_pixels[$];
   pix_type               oldest;

   // line state as the block should hold it
   logic [COLOR_BITS-1:0] color_reg;
   logic                  line_active;
   coord_type             col_pos, row_pos;
   coord_type             col_span, row_span, major_span;
   err_type               col_acc, row_acc;
   logic [1:0]            col_step, row_step;
   logic [COORD_BITS:0]   pixels_to_go;
   int                    errs = 0;

   // one step along dir, held at both ends of the coordinate range
   function automatic coord_type nudge(input coord_type pos, input logic [1:0] dir);
      coord_type edge_hi;
      edge_hi = '1;
      if (dir == DIR_INC && pos != edge_hi) return pos + 1'b1;
      if (dir == DIR_DEC && pos != '0) return pos - 1'b1;
      return pos;
   endfunction

   task automatic load_line(input logic [39:0] d);
      coord_type xs, ys, xe, ye;
      xs = coord_type'(d[9:0]);
      ys = coord_type'(d[19:10]);
      xe = coord_type'(d[29:20]);
      ye = coord_type'(d[39:30]);
      col_step     = (xe > xs) ? DIR_INC : (xe < xs) ? DIR_DEC : DIR_NONE;
      row_step     = (ye > ys) ? DIR_INC : (ye < ys) ? DIR_DEC : DIR_NONE;
      col_span     = (xe > xs) ? xe - xs : xs - xe;
      row_span     = (ye > ys) ? ye - ys : ys - ye;
      major_span   = (col_span > row_span) ? col_span : row_span;
      col_pos      = xs;
      row_pos      = ys;
      col_acc      = '0;
      row_acc      = '0;
      pixels_to_go = {1'b0, major_span} + 2'd2;
      line_active  = 1'b1;
   endtask

   task automatic emit_pixel();
      pix_type p;
      p.pixel_x     = FIELD_BITS'(col_pos);
      p.pixel_y     = FIELD_BITS'(row_pos);
      p.pixel_color = color_reg;
      pixels_to_go  = pixels_to_go - 1'b1;
      p.last        = (pixels_to_go == '0);
      if (pixels_to_go == '0) line_active = 1'b0;
      owed_pixels.push_back(p);
      col_acc = col_acc + err_type'(col_span);
      if (col_acc > err_type'(major_span)) begin
         col_acc = col_acc - err_type'(major_span);
         col_pos = nudge(col_pos, col_step);
      end
      row_acc = row_acc + err_type'(row_span);
      if (row_acc > err_type'(major_span)) begin
         row_acc = row_acc - err_type'(major_span);
         row_pos = nudge(row_pos, row_step);
      end
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_pixels.delete();
         color_reg    = '0;
         line_active  = 1'b0;
         col_pos      = '0;
         row_pos      = '0;
         col_acc      = '0;
         row_acc      = '0;
         col_span     = '0;
         row_span     = '0;
         major_span   = '0;
         col_step     = DIR_NONE;
         row_step     = DIR_NONE;
         pixels_to_go = '0;
      end else begin
         if (csr_wr_en) color_reg = csr_wr_data;

         if (rsp_tvalid && rsp_tready) begin
            if (owed_pixels.size() == 0) begin
               $display("%0t: pixel expected none, actual x=%0d y=%0d color=%h last=%b",
                        $time, rsp_tdata[9:0], rsp_tdata[19:10], rsp_tdata[35:20],
                        rsp_tlast);
               errs++;
            end else begin
               oldest = owed_pixels.pop_front();
               check_field("pixel_x", oldest.pixel_x, rsp_tdata[9:0]);
               check_field("pixel_y", oldest.pixel_y, rsp_tdata[19:10]);
               check_field("pixel_color", oldest.pixel_color, rsp_tdata[35:20]);
               check_field("last", oldest.last, rsp_tlast);
               check_field("tdata pad", 0, rsp_tdata[39:36]);
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser == ACT_START) load_line(req_tdata);
            else if (line_active) emit_pixel();
         end
      end
      fail_count     <= errs;
      pixels_pending <= owed_pixels.size();
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import lps_pkg::*;

   // 12 ns clock, reset held high at start-up
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   // input channel: tdata = x_start, y_start, x_end, y_end from bit 0 up
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        req_tuser  = ACT_START;

   // result channel
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   // color register
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;

   int          fail_count;
   int          pixels_pending;

   int          items_sent = 0;
   bit          calm       = 1'b0;  // no idling on either side once set
   int          stall_left = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   line_pixel_stepper_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   line_pixel_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .pixels_pending (pixels_pending)
   );

   // Receiver back-pressure: rsp_tready drops in random bursts, none when calm.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // One transfer on the input channel. tvalid stays high into the next
   // item unless a sender gap is drawn here.
   task automatic push_item(input logic act, input logic [39:0] data);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_start(input logic [9:0] xs, input logic [9:0] ys,
                             input logic [9:0] xe, input logic [9:0] ye);
      push_item(ACT_START, {ye, xe, ys, xs});
   endtask

   // tdata is don't-care on an advance; keep it noisy
   task automatic send_advances(input int n);
      repeat (n) push_item(ACT_ADVANCE, 40'({$urandom(), $urandom()}));
   endtask

   // Stop sending, let every owed pixel out, then allow for pipeline latency.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_color(input logic [15:0] c);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // endpoints lean toward the edges of the coordinate range
   function automatic logic [9:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 10'd0;
      if (r == 1) return 10'd1023;
      return 10'($urandom_range(0, 1023));
   endfunction

   function automatic logic [9:0] near(input logic [9:0] base, input int reach);
      int v;
      v = int'(base) - reach + int'($urandom_range(0, 2 * reach));
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return 10'(v);
   endfunction

   // Mostly complete lines with random endpoints; the rest are lines cut
   // short by a restart, lines overrun into idle advances, and stray advances.
   task automatic random_line();
      logic [9:0] xs, ys, xe, ye;
      int         kind, reach, dx, dy, major, cap;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         send_advances($urandom_range(1, 3));
         return;
      end
      xs    = pick_coord();
      ys    = pick_coord();
      reach = ($urandom_range(0, 19) == 0) ? 80 : 12;
      if (kind < 20) begin
         xe = pick_coord();
         ye = pick_coord();
      end else begin
         xe = near(xs, reach);
         ye = near(ys, reach);
      end
      dx    = (xe > xs) ? xe - xs : xs - xe;
      dy    = (ye > ys) ? ye - ys : ys - ye;
      major = (dx > dy) ? dx : dy;
      send_start(xs, ys, xe, ye);
      if (kind < 20) begin
         // long line, abandoned after a few pixels
         cap = (major + 1 < 10) ? major + 1 : 10;
         send_advances($urandom_range(0, cap));
      end else if (kind < 32) begin
         send_advances(major + 2 + $urandom_range(1, 3));
      end else if (kind < 40) begin
         send_advances($urandom_range(0, major + 1));
      end else begin
         send_advances(major + 2);
      end
   endtask

   initial begin
      logic [15:0] phase_color [4];
      int          phase_end;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: advance while idle
      send_advances(1);
      // zero-length line at the origin: two pixels, then an idle advance
      write_color(16'h0000);
      send_start(10'd0, 10'd0, 10'd0, 10'd0);
      send_advances(3);
      // far corner, full-scale color
      write_color(16'hFFFF);
      send_start(10'd1023, 10'd1023, 10'd1023, 10'd1023);
      send_advances(2);
      // diagonal toward lower column, higher row, starting at the range edge
      send_start(10'd1023, 10'd0, 10'd1020, 10'd3);
      send_advances(5);
      // full-range line, then a restart while it is still running
      write_color(16'($urandom()));
      send_start(10'd0, 10'd1023, 10'd1023, 10'd0);
      send_advances(3);
      send_start(10'd10, 10'd20, 10'd14, 10'd22);
      send_advances(6);

      // random phases, each under its own color
      phase_color[0] = 16'hFFFF;
      phase_color[1] = 16'($urandom());
      phase_color[2] = 16'h0000;
      phase_color[3] = 16'($urandom());
      foreach (phase_color[p]) begin
         write_color(phase_color[p]);
         phase_end = items_sent + 380;
         while (items_sent < phase_end) begin
            random_line();
            if (items_sent >= 1330) calm = 1'b1;
         end
      end

      wait_drained();
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2400000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
